>>> src/escaped_api_frame_receiver_assert.svh
// Assertion macros for the escaped API frame receiver.
// Used by src/escaped_api_frame_receiver.sv; the including module must have clk and arst_n.
`ifndef ESCAPED_API_FRAME_RECEIVER_ASSERT_SVH
`define ESCAPED_API_FRAME_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked outside reset.
`define EAFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define EAFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EAFR_ASSERT(lbl, prop, msg)
`define EAFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/eafr_pkg.sv
// Package for the escaped API frame receiver: framing bytes, frame types, result kinds.
// No dependencies; imported by escaped_api_frame_receiver.
`timescale 1ns / 1ps
package eafr_pkg;
	localparam logic [7:0] DELIM_BYTE = 8'h7e;
	localparam logic [7:0] ESC_BYTE = 8'h7d;
	localparam logic [7:0] ESC_XOR = 8'h20;
	localparam logic [7:0] SUM_GOOD = 8'hff;
	localparam logic [15:0] MAX_LENGTH_RESET = 16'd150;
	localparam logic [15:0] NET_ADDR_LIMIT = 16'hfffd;

	localparam logic [7:0] FT_RX_64 = 8'h90;
	localparam logic [7:0] FT_RX_IO = 8'h92;
	localparam logic [7:0] FT_NODE_ID = 8'h95;
	localparam logic [7:0] FT_SENSOR = 8'h97;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_GOOD = 2'd1;
	localparam logic [1:0] KIND_BAD = 2'd2;
	localparam logic [1:0] KIND_ABORT = 2'd3;

	// Payload offset of the low 32 bits of the source address; zero for frame types without one.
	function automatic logic [2:0] addr_offset(input logic [7:0] ft);
		logic [2:0] off;
		off = 3'd0;
		if (ft inside {FT_RX_64, FT_RX_IO, FT_NODE_ID}) begin
			off = 3'd5;
		end else if (ft == FT_SENSOR) begin
			off = 3'd6;
		end
		return off;
	endfunction
endpackage

>>> src/escaped_api_frame_receiver.sv
// Escaped API frame receiver: top level, input register, deframing logic and result register.
// Depends on eafr_pkg and escaped_api_frame_receiver_assert.svh.
`timescale 1ns / 1ps
`include "escaped_api_frame_receiver_assert.svh"

// The receiver takes one raw serial byte per clock and gives at most one result per byte:
// a payload byte, a frame end with checksum verdict and captured addresses, or an abort.
// A byte passes through the input register and one stage of deframing logic into the
// result register, and a new byte can be transferred every cycle. Only a held result
// (out_stall high while out_valid is high) stops the flow; in_stall then rises once the
// input register is full. max_length may be written only while no byte is in flight.
module escaped_api_frame_receiver
	import eafr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] byte_index,
	output logic [15:0] frame_length,
	output logic [31:0] src_addr_low,
	output logic [15:0] net_addr,
	output logic        addr_valid
);
	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_CHECK
	} phase_t;

	logic [15:0] max_length_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;

	phase_t      phase_q, phase_d;
	logic        esc_q, esc_d;
	logic [15:0] length_q, length_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  ftype_q, ftype_d;
	logic [31:0] addr_q, addr_d;
	logic [15:0] net_q, net_d;

	logic        res_valid;
	logic [1:0]  res_kind;
	logic [7:0]  res_data;
	logic [15:0] res_index;
	logic [31:0] res_src;
	logic [15:0] res_net;
	logic        res_addr_valid;

	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [7:0]  data_q;
	logic [15:0] index_q;
	logic [15:0] flen_q;
	logic [31:0] src_q;
	logic [15:0] netout_q;
	logic        addr_valid_q;

	logic        advance;
	logic        proc;

	// The result register can load when it is empty or being emptied this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign proc     = advance && valid_s1;
	assign in_stall = valid_s1 && !advance;

	always_comb begin
		logic [7:0]  d;
		logic [2:0]  off;
		logic [16:0] idx_x;
		logic [16:0] off_x;
		logic [7:0]  sum_new;
		logic        good;

		phase_d        = phase_q;
		esc_d          = esc_q;
		length_d       = length_q;
		count_d        = count_q;
		sum_d          = sum_q;
		ftype_d        = ftype_q;
		addr_d         = addr_q;
		net_d          = net_q;
		res_valid      = 1'b0;
		res_kind       = KIND_DATA;
		res_data       = 8'd0;
		res_index      = count_q;
		res_src        = 32'd0;
		res_net        = 16'd0;
		res_addr_valid = 1'b0;
		d              = esc_q ? (byte_s1 ^ ESC_XOR) : byte_s1;
		off            = 3'd0;
		idx_x          = {1'b0, count_q};
		off_x          = 17'd0;
		sum_new        = sum_q + d;
		good           = (sum_new == SUM_GOOD);

		if (byte_s1 == DELIM_BYTE) begin
			// A raw delimiter always restarts; a frame whose payload has begun is aborted.
			if (phase_q inside {PH_PAYLOAD, PH_CHECK} && count_q != 16'd0) begin
				res_valid = 1'b1;
				res_kind  = KIND_ABORT;
			end
			phase_d = PH_LEN_HI;
			esc_d   = 1'b0;
		end else if (byte_s1 == ESC_BYTE) begin
			esc_d = 1'b1;
		end else begin
			esc_d = 1'b0;
			case (phase_q)
				PH_LEN_HI: begin
					length_d = {d, 8'd0};
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					length_d = {length_q[15:8], d};
					sum_d    = 8'd0;
					count_d  = 16'd0;
					ftype_d  = 8'd0;
					addr_d   = 32'd0;
					net_d    = 16'd0;
					if (length_d > max_length_q) begin
						phase_d = PH_IDLE;
					end else if (length_d == 16'd0) begin
						phase_d = PH_CHECK;
					end else begin
						phase_d = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					sum_d = sum_new;
					if (count_q == 16'd0) begin
						ftype_d = d;
					end
					off   = addr_offset(ftype_d);
					off_x = {14'd0, off};
					if (off != 3'd0) begin
						if (idx_x >= off_x && idx_x < off_x + 17'd4) begin
							addr_d = {addr_q[23:0], d};
						end else if (idx_x >= off_x + 17'd4 && idx_x < off_x + 17'd6) begin
							net_d = {net_q[7:0], d};
						end
					end
					count_d   = count_q + 16'd1;
					res_valid = 1'b1;
					res_kind  = KIND_DATA;
					res_data  = d;
					if (count_d >= length_q) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					sum_d     = sum_new;
					off       = addr_offset(ftype_q);
					off_x     = {14'd0, off};
					res_valid = 1'b1;
					res_kind  = good ? KIND_GOOD : KIND_BAD;
					if (off != 3'd0) begin
						res_src        = addr_q;
						res_net        = net_q;
						res_addr_valid = good && idx_x >= off_x + 17'd6
							&& net_q < NET_ADDR_LIMIT;
					end
					phase_d = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
			valid_s1     <= 1'b0;
			phase_q      <= PH_IDLE;
			esc_q        <= 1'b0;
			length_q     <= 16'd0;
			count_q      <= 16'd0;
			sum_q        <= 8'd0;
			ftype_q      <= 8'd0;
			addr_q       <= 32'd0;
			net_q        <= 16'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_length_q <= cfg_wr_data;
			end
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (proc) begin
				phase_q  <= phase_d;
				esc_q    <= esc_d;
				length_q <= length_d;
				count_q  <= count_d;
				sum_q    <= sum_d;
				ftype_q  <= ftype_d;
				addr_q   <= addr_d;
				net_q    <= net_d;
			end
			if (advance) begin
				out_valid_q <= proc && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= rx_byte;
		end
		if (proc && res_valid) begin
			kind_q       <= res_kind;
			data_q       <= res_data;
			index_q      <= res_index;
			flen_q       <= length_q;
			src_q        <= res_src;
			netout_q     <= res_net;
			addr_valid_q <= res_addr_valid;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign byte_index   = index_q;
	assign frame_length = flen_q;
	assign src_addr_low = src_q;
	assign net_addr     = netout_q;
	assign addr_valid   = addr_valid_q;

	`EAFR_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> valid_s1, "in_stall without a waiting byte")
	`EAFR_ASSERT(a_delim_restarts, proc && byte_s1 == DELIM_BYTE |=> phase_q == PH_LEN_HI && !esc_q, "delimiter did not restart the frame")
	`EAFR_ASSERT(a_payload_in_range, phase_q == PH_PAYLOAD |-> count_q < length_q, "payload count reached the frame length")
	`EAFR_ASSERT(a_index_below_length, out_valid_q && kind_q == KIND_DATA |-> index_q < flen_q, "payload index beyond frame length")
	`EAFR_ASSERT(a_addr_valid_good, out_valid_q && addr_valid_q |-> kind_q == KIND_GOOD, "address flagged valid on a frame that is not good")
endmodule

>>> verif/escaped_api_frame_receiver_tb.sv
// Self-checking testbench for escaped_api_frame_receiver: directed frames, then random traffic.
// Depends on eafr_pkg and the receiver RTL; results are checked against an in-bench deframer.
`timescale 1ns / 1ps

module escaped_api_frame_receiver_tb;
	import eafr_pkg::*;

	localparam int CLK_PERIOD = 20;
	localparam int RESET_CYCLES = 9;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;
	localparam int BYTES_PER_PHASE = 90;

	typedef enum logic [2:0] {
		HUNT = 3'd0,
		LEN_HI = 3'd1,
		LEN_LO = 3'd2,
		PAYLOAD = 3'd3,
		CHECKSUM = 3'd4
	} deframe_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [15:0] frame_length;
		logic [31:0] src_addr_low;
		logic [15:0] net_addr;
		logic        addr_valid;
	} frame_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = 16'd0;
	logic        in_valid = 1'b0;
	logic [7:0]  rx_byte = 8'd0;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] byte_index;
	logic [15:0] frame_length;
	logic [31:0] src_addr_low;
	logic [15:0] net_addr;
	logic        addr_valid;

	// Deframer state kept by the bench, updated on every accepted byte.
	deframe_state_t st_phase = HUNT;
	logic           st_esc = 1'b0;
	logic [15:0]    st_len = 16'd0;
	logic [15:0]    st_count = 16'd0;
	logic [15:0]    st_max_len = MAX_LENGTH_RESET;
	logic [7:0]     st_sum = 8'd0;
	logic [7:0]     st_type = 8'd0;
	logic [31:0]    st_src = 32'd0;
	logic [15:0]    st_net = 16'd0;

	frame_result_t expected_results[$];
	logic [7:0]    pending_bytes[$];
	bit            in_fire = 1'b0;
	int            cycle_count = 0;
	int            mismatch_count = 0;
	int            send_idle_pct = 0;
	int            stall_pct = 0;

	escaped_api_frame_receiver u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.data_byte   (data_byte),
		.byte_index  (byte_index),
		.frame_length(frame_length),
		.src_addr_low(src_addr_low),
		.net_addr    (net_addr),
		.addr_valid  (addr_valid)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic int source_addr_offset(input logic [7:0] ft);
		case (ft)
		FT_RX_64, FT_RX_IO, FT_NODE_ID: return 5;
		FT_SENSOR: return 6;
		default: return 0;
		endcase
	endfunction

	function automatic string result_text(input frame_result_t r);
		return $sformatf("kind=%0d data=%02h idx=%0d len=%0d src=%08h net=%04h av=%0b",
			r.kind, r.data_byte, r.byte_index, r.frame_length, r.src_addr_low,
			r.net_addr, r.addr_valid);
	endfunction

	// Advances the bench deframer by one raw byte and queues any result it gives.
	task automatic deframe_byte(input logic [7:0] raw);
		logic [7:0]    d;
		logic [15:0]   idx;
		int            off;
		logic          good;
		frame_result_t r;
		r = '0;
		r.frame_length = st_len;
		if (raw == DELIM_BYTE) begin
			// A frame cut short after its payload began is reported as an abort.
			if ((st_phase == PAYLOAD || st_phase == CHECKSUM) && st_count != 16'd0) begin
				r.kind = KIND_ABORT;
				r.byte_index = st_count;
				expected_results.push_back(r);
			end
			st_phase = LEN_HI;
			st_esc = 1'b0;
		end else if (raw == ESC_BYTE) begin
			st_esc = 1'b1;
		end else begin
			d = st_esc ? (raw ^ ESC_XOR) : raw;
			st_esc = 1'b0;
			case (st_phase)
			LEN_HI: begin
				st_len = {d, 8'h00};
				st_phase = LEN_LO;
			end
			LEN_LO: begin
				st_len = {st_len[15:8], d};
				st_sum = 8'd0;
				st_count = 16'd0;
				st_type = 8'd0;
				st_src = 32'd0;
				st_net = 16'd0;
				if (st_len > st_max_len) begin
					st_phase = HUNT;
				end else if (st_len == 16'd0) begin
					st_phase = CHECKSUM;
				end else begin
					st_phase = PAYLOAD;
				end
			end
			PAYLOAD: begin
				st_sum = st_sum + d;
				idx = st_count;
				if (idx == 16'd0) begin
					st_type = d;
				end
				off = source_addr_offset(st_type);
				if (off != 0) begin
					if (idx >= off && idx < off + 4) begin
						st_src = {st_src[23:0], d};
					end else if (idx >= off + 4 && idx < off + 6) begin
						st_net = {st_net[7:0], d};
					end
				end
				st_count = idx + 16'd1;
				r.kind = KIND_DATA;
				r.data_byte = d;
				r.byte_index = idx;
				expected_results.push_back(r);
				if (st_count >= st_len) begin
					st_phase = CHECKSUM;
				end
			end
			CHECKSUM: begin
				st_sum = st_sum + d;
				good = (st_sum == SUM_GOOD);
				off = source_addr_offset(st_type);
				r.kind = good ? KIND_GOOD : KIND_BAD;
				r.byte_index = st_count;
				if (off != 0) begin
					r.src_addr_low = st_src;
					r.net_addr = st_net;
					r.addr_valid = good && st_count >= off + 6 && st_net < NET_ADDR_LIMIT;
				end
				expected_results.push_back(r);
				st_phase = HUNT;
			end
			default: st_phase = HUNT;
			endcase
		end
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, what);
		end
	endtask

	// Input transfers feed the bench deframer; output transfers are checked in order.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		cycle_count++;
		in_fire = arst_n && in_valid && !in_stall;
		if (in_fire) begin
			deframe_byte(rx_byte);
		end
		if (arst_n && out_valid && !out_stall) begin
			got = {kind, data_byte, byte_index, frame_length, src_addr_low, net_addr,
				addr_valid};
			if (expected_results.size() == 0) begin
				report_mismatch({"unexpected result: ", result_text(got)});
			end else begin
				want = expected_results.pop_front();
				if (got != want) begin
					report_mismatch({"expected ", result_text(want), " got ",
						result_text(got)});
				end
			end
		end
	end

	// Sender and receiver sides; both change only on the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			if (!in_valid || in_fire) begin
				if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Framing bytes must be escaped; other bytes are escaped now and then, except those
	// whose escaped form would itself be a framing byte.
	task automatic push_escaped(input logic [7:0] value, input int esc_pct);
		logic [7:0] flipped;
		flipped = value ^ ESC_XOR;
		if (value == DELIM_BYTE || value == ESC_BYTE || ($urandom_range(99) < esc_pct
				&& flipped != DELIM_BYTE && flipped != ESC_BYTE)) begin
			if ($urandom_range(15) == 0) begin
				pending_bytes.push_back(ESC_BYTE);
			end
			pending_bytes.push_back(ESC_BYTE);
			pending_bytes.push_back(flipped);
		end else begin
			pending_bytes.push_back(value);
		end
	endtask

	// Sends the delimiter, the length and the first bytes of the body; keep counts payload
	// bytes and then the checksum, so keep below len + 1 leaves the frame unfinished.
	task automatic push_frame(input logic [15:0] len, input logic [7:0] body[$], input bit good,
			input int keep, input int esc_pct);
		logic [7:0] sum;
		sum = 8'd0;
		foreach (body[i]) sum += body[i];
		pending_bytes.push_back(DELIM_BYTE);
		push_escaped(len[15:8], esc_pct);
		push_escaped(len[7:0], esc_pct);
		for (int i = 0; i < keep && i < body.size(); i++) begin
			push_escaped(body[i], esc_pct);
		end
		if (keep > len && body.size() == len) begin
			push_escaped(good ? SUM_GOOD - sum : SUM_GOOD - sum + 8'($urandom_range(1, 255)),
				esc_pct);
		end
	endtask

	task automatic build_body(input int len, input logic [7:0] ftype, input bit reserved_net,
			output logic [7:0] body[$]);
		int off;
		body = {};
		for (int i = 0; i < len; i++) begin
			body.push_back(8'($urandom_range(255)));
		end
		if (len > 0) begin
			body[0] = ftype;
		end
		off = source_addr_offset(ftype);
		if (reserved_net && off != 0 && len >= off + 6) begin
			body[off + 4] = 8'hff;
			body[off + 5] = 8'($urandom_range(8'hfc, 8'hff));
		end
	endtask

	task automatic random_traffic(input int budget);
		int          sent;
		int          start;
		int          len;
		int          off;
		int          keep;
		int          pick;
		int          cap;
		logic [7:0]  ftype;
		logic [7:0]  body[$];
		sent = 0;
		while (sent < budget) begin
			start = pending_bytes.size();
			pick = $urandom_range(99);
			if (pick < 8) begin
				// Line noise between frames; the block ignores most of it.
				repeat ($urandom_range(1, 4)) pending_bytes.push_back(8'($urandom_range(255)));
				sent += pending_bytes.size() - start;
			end else if (pick < 14) begin
				// A header broken off by a fresh delimiter part way through the length.
				pending_bytes.push_back(DELIM_BYTE);
				if ($urandom_range(1)) begin
					push_escaped(8'($urandom_range(255)), 10);
				end
				sent += pending_bytes.size() - start;
			end else begin
				case ($urandom_range(5))
				0: ftype = FT_RX_64;
				1: ftype = FT_RX_IO;
				2: ftype = FT_NODE_ID;
				3: ftype = FT_SENSOR;
				default: ftype = 8'($urandom_range(255));
				endcase
				off = source_addr_offset(ftype);
				cap = (st_max_len > 14) ? 14 : st_max_len;
				pick = $urandom_range(99);
				if (pick < 6) begin
					// Oversized lengths, or very long ones that can only end in an abort.
					if (st_max_len == 16'hffff) begin
						len = $urandom_range(1) ? 65535 : $urandom_range(41, 65535);
					end else if ($urandom_range(1)) begin
						len = 65535;
					end else begin
						len = st_max_len + 1 + $urandom_range(2);
						if (len > 65535) len = 65535;
					end
				end else if (pick < 12) begin
					len = (st_max_len <= 40) ? st_max_len : $urandom_range(15, 40);
				end else if (off != 0 && $urandom_range(3) != 0 && st_max_len >= off + 6) begin
					len = $urandom_range(off + 6, (st_max_len < off + 10) ? st_max_len : off + 10);
				end else begin
					len = $urandom_range(0, cap);
				end
				build_body((len > 48) ? 48 : len, ftype, $urandom_range(3) == 0, body);
				if (len > st_max_len) begin
					keep = $urandom_range(0, 3);
				end else if ($urandom_range(99) < 8) begin
					keep = $urandom_range(0, body.size());
				end else begin
					keep = len + 1;
				end
				push_frame(16'(len), body, $urandom_range(99) < 85, keep, 8);
				sent += pending_bytes.size() - start;
			end
		end
	endtask

	// The sender holds off until every expected result is back and the block has gone quiet.
	task automatic wait_drained();
		while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_max_length(input logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		st_max_len = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(input logic [15:0] max_len, input int idle, input int stall);
		write_max_length(max_len);
		send_idle_pct = idle;
		stall_pct = stall;
		random_traffic(BYTES_PER_PHASE);
		wait_drained();
	endtask

	initial begin
		logic [7:0] body[$];
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Stray bytes before any delimiter, one of them an escape that is never used.
		pending_bytes.push_back(8'h11);
		pending_bytes.push_back(ESC_BYTE);
		pending_bytes.push_back(8'h41);
		// Source address frame carrying an escaped delimiter value in its payload.
		build_body(11, FT_RX_64, 1'b0, body);
		body[1] = DELIM_BYTE;
		body[9] = 8'h12;
		body[10] = 8'h34;
		push_frame(16'd11, body, 1'b1, 12, 0);
		// Sensor frame with a reserved network address, every byte escaped where possible.
		build_body(12, FT_SENSOR, 1'b0, body);
		body[10] = 8'hff;
		body[11] = 8'hfd;
		push_frame(16'd12, body, 1'b1, 13, 100);
		// Address-bearing frame too short to hold the whole address.
		build_body(7, FT_RX_IO, 1'b0, body);
		push_frame(16'd7, body, 1'b1, 8, 0);
		// Bad checksum, with all-zero and all-one payload bytes.
		build_body(11, FT_NODE_ID, 1'b0, body);
		body[1] = 8'h00;
		body[2] = 8'hff;
		push_frame(16'd11, body, 1'b0, 12, 0);
		// Zero length, then a zero-length frame cut in its checksum phase with nothing to abort.
		body = {};
		push_frame(16'd0, body, 1'b1, 1, 0);
		push_frame(16'd0, body, 1'b1, 0, 0);
		// Lengths just above the limit and at the top of the range are dropped.
		push_frame(16'd151, body, 1'b1, 0, 0);
		pending_bytes.push_back(8'h55);
		push_frame(16'hffff, body, 1'b1, 0, 0);
		// Payload cut by a delimiter, then a frame cut in its checksum phase.
		build_body(5, 8'h10, 1'b0, body);
		push_frame(16'd5, body, 1'b1, 3, 0);
		build_body(2, 8'h20, 1'b0, body);
		push_frame(16'd2, body, 1'b1, 2, 0);
		// Delimiter inside the length, then a repeated escape before payload 0x7d.
		pending_bytes.push_back(DELIM_BYTE);
		pending_bytes.push_back(8'h00);
		pending_bytes = {pending_bytes, DELIM_BYTE, 8'h00, 8'h02, ESC_BYTE, ESC_BYTE, 8'h5d,
			8'h41, 8'h41};
		wait_drained();

		run_phase(16'hffff, 0, 0);
		run_phase(16'd0, 56, 0);
		run_phase(16'd20, 0, 56);
		run_phase(16'd150, 15, 15);
		run_phase(16'd6, 56, 0);

		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

endmodule
